[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ppmp_pkg.sv]
`default_nettype none

package ppmp_pkg;

  localparam int unsigned DimBits = 16;
  localparam int unsigned AccumW = ((DimBits > 8) ? DimBits : 8) + 1;
  localparam int unsigned PixW = 2 * DimBits;
  localparam longint unsigned DimMax = (64'd1 << DimBits) - 64'd1;
  localparam longint unsigned AccumCap = 64'd1 << (AccumW - 1);

  localparam logic [7:0] ChP = 8'h50;
  localparam logic [7:0] Ch6 = 8'h36;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChNl = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChVt = 8'h0B;
  localparam logic [7:0] ChFf = 8'h0C;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] AlphaOpaque = 8'hFF;
  localparam logic [7:0] MaxvalReq = 8'd255;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindPixel  = 2'd1,
    KindError  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ErrBadMagic    = 2'd0,
    ErrBadNumber   = 2'd1,
    ErrTruncHeader = 2'd2,
    ErrTruncPixels = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_pixel;
  } out_t;

  typedef struct packed {
    logic add;
    logic clear;
  } tok_ctl_t;

  typedef struct packed {
    logic               active;
    logic               magic_ok;
    logic               dim_ok;
    logic               maxval_ok;
    logic [DimBits-1:0] value;
  } tok_stat_t;

endpackage

`default_nettype wire

[rtl/ppmp_tok.sv]
`default_nettype none

module ppmp_tok import ppmp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire tok_ctl_t  ctl_i,
  input  wire logic [7:0] char_i,
  output tok_stat_t      stat_o
);

  logic              active_q, active_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              inv_q, inv_d;
  logic [AccumW-1:0] accum_q, accum_d;
  logic              neg_q, neg_d;
  logic              seen_q, seen_d;
  logic              done_q, done_d;
  logic              is_digit;
  logic [AccumW+3:0] acc10;

  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  assign acc10 = {accum_q, 4'b0} - {2'b0, accum_q, 2'b0} - {3'b0, accum_q, 1'b0}
               + {(AccumW + 4)'(char_i - ChZero)};

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    inv_d    = inv_q;
    accum_d  = accum_q;
    neg_d    = neg_q;
    seen_d   = seen_q;
    done_d   = done_q;
    if (ctl_i.clear) begin
      active_d = 1'b0;
      cnt_d    = 2'd0;
      inv_d    = 1'b0;
      accum_d  = '0;
      neg_d    = 1'b0;
      seen_d   = 1'b0;
      done_d   = 1'b0;
    end else if (ctl_i.add) begin
      if ((cnt_q == 2'd0 && char_i != ChP) || (cnt_q == 2'd1 && char_i != Ch6)) begin
        inv_d = 1'b1;
      end
      if (cnt_q == 2'd0 && (char_i == ChPlus || char_i == ChMinus)) begin
        neg_d = (char_i == ChMinus);
      end else if (!done_q && is_digit) begin
        // saturate so that huge numbers still fail the range check
        if (acc10 > (AccumW + 4)'(AccumCap)) begin
          accum_d = AccumW'(AccumCap);
        end else begin
          accum_d = acc10[AccumW-1:0];
        end
        seen_d = 1'b1;
      end else begin
        done_d = 1'b1;
      end
      if (cnt_q != 2'd3) begin
        cnt_d = cnt_q + 2'd1;
      end
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= 2'd0;
      inv_q    <= 1'b0;
      accum_q  <= '0;
      neg_q    <= 1'b0;
      seen_q   <= 1'b0;
      done_q   <= 1'b0;
    end else if (step_i) begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      inv_q    <= inv_d;
      accum_q  <= accum_d;
      neg_q    <= neg_d;
      seen_q   <= seen_d;
      done_q   <= done_d;
    end
  end

  always_comb begin
    stat_o.active    = active_q;
    stat_o.magic_ok  = (cnt_q == 2'd2) && !inv_q;
    stat_o.dim_ok    = seen_q && !neg_q && (accum_q != '0)
                     && (accum_q <= AccumW'(DimMax));
    stat_o.maxval_ok = seen_q && !neg_q && (accum_q == AccumW'(MaxvalReq));
    stat_o.value     = accum_q[DimBits-1:0];
  end

endmodule

`default_nettype wire

[rtl/ppmp_ctrl.sv]
`default_nettype none

`include "assert_macros.svh"

module ppmp_ctrl import ppmp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire in_t       word_i,
  input  wire tok_stat_t tok_stat_i,
  output tok_ctl_t       tok_ctl_o,
  output logic           res_valid_o,
  output out_t           res_word_o
);

  localparam logic [2:0] PhMagic  = 3'd0;
  localparam logic [2:0] PhWidth  = 3'd1;
  localparam logic [2:0] PhHeight = 3'd2;
  localparam logic [2:0] PhMaxval = 3'd3;
  localparam logic [2:0] PhPixels = 3'd4;
  localparam logic [2:0] PhDrain  = 3'd5;
  localparam logic [2:0] PhDone   = 3'd6;

  logic [2:0]         phase_q, phase_d;
  logic               cmt_q, cmt_d;
  logic               pend_q, pend_d;
  logic [DimBits-1:0] width_q, width_d;
  logic [DimBits-1:0] height_q, height_d;
  logic [PixW-1:0]    prod_q;
  logic [PixW-1:0]    left_q, left_d;
  logic [1:0]         bip_q, bip_d;
  logic [7:0]         red_q, red_d;
  logic [7:0]         green_q, green_d;
  logic [7:0]         c;
  logic               is_ws;
  logic               hdr_res;
  logic               last_res;

  assign c = word_i.data_byte;
  assign is_ws = (c == ChSpace) || (c == ChTab) || (c == ChNl) || (c == ChVt)
              || (c == ChFf) || (c == ChCr);

  always_comb begin
    phase_d     = phase_q;
    cmt_d       = cmt_q;
    pend_d      = pend_q;
    width_d     = width_q;
    height_d    = height_q;
    left_d      = left_q;
    bip_d       = bip_q;
    red_d       = red_q;
    green_d     = green_q;
    tok_ctl_o   = '0;
    res_valid_o = 1'b0;
    res_word_o  = '0;
    if (word_i.end_of_stream) begin
      // end of file: report an error if the image is unfinished, and go back to the start
      if (phase_q <= PhMaxval) begin
        res_valid_o = 1'b1;
        res_word_o.result_kind = KindError;
        res_word_o.error_code = ErrTruncHeader;
        if (tok_stat_i.active && phase_q == PhMagic && !tok_stat_i.magic_ok) begin
          res_word_o.error_code = ErrBadMagic;
        end else if (tok_stat_i.active && phase_q == PhMaxval) begin
          res_word_o.error_code = (pend_q || !tok_stat_i.maxval_ok) ? ErrBadNumber
                                                                     : ErrTruncPixels;
        end
      end else if (phase_q == PhPixels) begin
        res_valid_o = 1'b1;
        res_word_o.result_kind = KindError;
        res_word_o.error_code = ErrTruncPixels;
      end
      phase_d         = PhMagic;
      cmt_d           = 1'b0;
      pend_d          = 1'b0;
      left_d          = '0;
      bip_d           = 2'd0;
      tok_ctl_o.clear = 1'b1;
    end else if (phase_q == PhDrain || phase_q == PhDone) begin
      phase_d = phase_q;
    end else if (cmt_q) begin
      if (c == ChNl) begin
        cmt_d = 1'b0;
      end
    end else if (phase_q == PhPixels) begin
      case (bip_q)
        2'd0: begin
          red_d = c;
          bip_d = 2'd1;
        end
        2'd1: begin
          green_d = c;
          bip_d = 2'd2;
        end
        default: begin
          bip_d = 2'd0;
          left_d = left_q - PixW'(1);
          res_valid_o = 1'b1;
          res_word_o.result_kind = KindPixel;
          res_word_o.red = red_q;
          res_word_o.green = green_q;
          res_word_o.blue = c;
          res_word_o.alpha = AlphaOpaque;
          res_word_o.last_pixel = (left_q == PixW'(1));
          if (left_q == PixW'(1)) begin
            phase_d = PhDone;
          end
        end
      endcase
    end else if (is_ws || c == ChHash) begin
      if (c == ChHash) begin
        cmt_d = 1'b1;
      end
      if (tok_stat_i.active) begin
        tok_ctl_o.clear = 1'b1;
        unique case (phase_q)
          PhMagic: begin
            if (tok_stat_i.magic_ok) begin
              phase_d = PhWidth;
            end else begin
              res_valid_o = 1'b1;
              res_word_o.result_kind = KindError;
              res_word_o.error_code = ErrBadMagic;
              phase_d = PhDrain;
            end
          end
          PhWidth: begin
            if (!tok_stat_i.dim_ok) begin
              pend_d = 1'b1;
            end
            width_d = tok_stat_i.value;
            phase_d = PhHeight;
          end
          PhHeight: begin
            if (!tok_stat_i.dim_ok) begin
              pend_d = 1'b1;
            end
            height_d = tok_stat_i.value;
            phase_d = PhMaxval;
          end
          default: begin
            res_valid_o = 1'b1;
            if (pend_q || !tok_stat_i.maxval_ok) begin
              res_word_o.result_kind = KindError;
              res_word_o.error_code = ErrBadNumber;
              phase_d = PhDrain;
            end else begin
              res_word_o.result_kind = KindHeader;
              res_word_o.image_width = 16'(width_q);
              res_word_o.image_height = 16'(height_q);
              left_d = prod_q;
              bip_d = 2'd0;
              phase_d = PhPixels;
            end
          end
        endcase
      end
    end else begin
      tok_ctl_o.add = 1'b1;
    end
    if (!step_i) begin
      tok_ctl_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhMagic;
      cmt_q   <= 1'b0;
      pend_q  <= 1'b0;
      left_q  <= '0;
      bip_q   <= 2'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cmt_q   <= cmt_d;
      pend_q  <= pend_d;
      left_q  <= left_d;
      bip_q   <= bip_d;
    end
  end

  // dimensions settle at least two words before the header ends
  always_ff @(posedge clk_i) begin
    prod_q <= PixW'(width_q) * PixW'(height_q);
    if (step_i) begin
      width_q  <= width_d;
      height_q <= height_d;
      red_q    <= red_d;
      green_q  <= green_d;
    end
  end

  assign hdr_res  = step_i && res_valid_o && (res_word_o.result_kind == KindHeader);
  assign last_res = step_i && res_valid_o && res_word_o.last_pixel;

  `ASSERT_IMPLIES(a_left_nonzero, clk_i, rst_ni, phase_q == PhPixels, left_q != '0)
  `ASSERT_NEXT(a_hdr_to_pixels, clk_i, rst_ni, hdr_res, phase_q == PhPixels && bip_q == 2'd0)
  `ASSERT_NEXT(a_last_done, clk_i, rst_ni, last_res, phase_q == PhDone)

endmodule

`default_nettype wire

[rtl/ppm_p6_to_rgba_parser.sv]
// Binary PPM (P6) parser: takes the file one byte per word on the input channel
// and returns a header word (width, height), then one RGBA word per three pixel
// bytes with alpha 255 and the last pixel flagged, or an error word. A word with
// end_of_stream set closes the file and returns the parser to its start. One word
// is taken every cycle unless the output stalls; a result passes through an input
// register and a result register, and a full result register stalls the input
// only while it is not taken. Pixels already delivered before an error must be
// dropped downstream.
`default_nettype none

`include "assert_macros.svh"

module ppm_p6_to_rgba_parser import ppmp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_word_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_word_o
);

  logic      in_valid_q;
  in_t       in_word_q;
  logic      step;
  logic      res_valid;
  out_t      res_word;
  logic      out_valid_q;
  out_t      out_word_q;
  tok_ctl_t  tok_ctl;
  tok_stat_t tok_stat;
  logic      in_stall;
  logic      out_stall;

  assign step = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_word_i;
    end
  end

  ppmp_tok u_tok (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ctl_i  (tok_ctl),
    .char_i (in_word_q.data_byte),
    .stat_o (tok_stat)
  );

  ppmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .word_i      (in_word_q),
    .tok_stat_i  (tok_stat),
    .tok_ctl_o   (tok_ctl),
    .res_valid_o (res_valid),
    .res_word_o  (res_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign in_stall  = in_valid_q && out_valid_q && !out_ready_i;
  assign out_stall = out_valid_q && !out_ready_i;

  `ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, in_stall, in_valid_q && $stable(in_word_q))
  `ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_stall, out_valid_q && $stable(out_word_q))
  `ASSERT_NEXT(a_result_shown, clk_i, rst_ni, step && res_valid, out_valid_q)

endmodule

`default_nettype wire
